/* hw/rtl/tvs_pkg.sv */
// ----------------------------------------------------------------------------
// tvs_pkg
// Shared types and constants of the trilinear volume sampler: beat layouts,
// register indexes, the multiply-accumulate opcodes and parameter defaults.
// ----------------------------------------------------------------------------
package tvs_pkg;

    // Parameter defaults
    localparam int SIDE_DEF      = 64;
    localparam int FRAC_BITS_DEF = 8;

    // Voxel payload and result format
    localparam int VOXEL_W  = 16;
    localparam int COORD_W  = 16;
    localparam int INDEX_W  = 6;
    localparam int OUT_W    = 40;
    localparam int OUT_FRAC = 24;

    // Input tdata layout, lowest bit first
    localparam int VI_LSB     = 0;
    localparam int VJ_LSB     = VI_LSB + INDEX_W;
    localparam int VK_LSB     = VJ_LSB + INDEX_W;
    localparam int VVAL_LSB   = VK_LSB + INDEX_W;
    localparam int CX_LSB     = VVAL_LSB + VOXEL_W;
    localparam int CY_LSB     = CX_LSB + COORD_W;
    localparam int CZ_LSB     = CY_LSB + COORD_W;
    localparam int IN_FIELD_W = CZ_LSB + COORD_W;
    localparam int S_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((OUT_W + 7) / 8) * 8;

    // Beat kinds carried in s_tuser
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Extent registers
    localparam int          SIZE_W     = 7;
    localparam int          EXT_W      = 9;   // holds an extent up to 256
    localparam int          CFG_IDX_W  = 2;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2
    } cfg_reg_t;

    // Signed corner index width; covers floored Q-format coordinates plus offset
    localparam int IDX_W = 18;

    // Multiply-accumulate unit opcodes
    typedef enum logic [1:0] {
        MAC_IDLE = 2'd0,
        MAC_CLR  = 2'd1,
        MAC_MUL  = 2'd2,
        MAC_ACC  = 2'd3
    } mac_op_t;

endpackage

/* hw/rtl/tvs_ram.sv */
// ----------------------------------------------------------------------------
// tvs_ram
// Generic single-port RAM: one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
module tvs_ram #(
    parameter int WIDTH = tvs_pkg::VOXEL_W,
    parameter int DEPTH = tvs_pkg::SIDE_DEF * tvs_pkg::SIDE_DEF * tvs_pkg::SIDE_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable, otherwise read into the output register
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end else begin
            rdata <= mem[addr];
        end
    end

endmodule

/* hw/rtl/tvs_mac.sv */
// ----------------------------------------------------------------------------
// tvs_mac
// Shared multiplier with accumulator: signed operand times unsigned weight,
// product registered, optional accumulate into a running sum.
// ----------------------------------------------------------------------------
module tvs_mac #(
    parameter int A_W   = tvs_pkg::FRAC_BITS_DEF + 18,
    parameter int B_W   = 2 * tvs_pkg::FRAC_BITS_DEF + 1,
    parameter int ACC_W = 3 * tvs_pkg::FRAC_BITS_DEF + 18
) (
    input  logic                      aclk,
    input  tvs_pkg::mac_op_t          op,
    input  logic signed [A_W-1:0]     a,
    input  logic        [B_W-1:0]     b,
    output logic signed [A_W+B_W:0]   prod,
    output logic signed [ACC_W-1:0]   acc
);

    localparam int P_W = A_W + B_W + 1;

    logic signed [A_W+B_W:0] prod_next;
    logic signed [A_W+B_W:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    // Weight is unsigned: extend it with a zero sign bit
    assign prod_next = P_W'(a) * P_W'($signed({1'b0, b}));

    // Run the selected operation
    always_ff @(posedge aclk) begin
        case (op)
            tvs_pkg::MAC_CLR: begin
                acc_reg <= '0;
            end
            tvs_pkg::MAC_MUL: begin
                prod_reg <= prod_next;
            end
            tvs_pkg::MAC_ACC: begin
                acc_reg <= acc_reg + ACC_W'(prod_next);
            end
            default: begin
            end
        endcase
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

/* hw/rtl/trilinear_volume_sampler.sv */
// ----------------------------------------------------------------------------
// trilinear_volume_sampler
// Voxel volume held in one single-port RAM; sample beats return the exact
// trilinear interpolation of the eight surrounding voxels.
//
//   Channel   Dir  Beat contents
//   s_        in   tuser: kind; tdata: voxel index, voxel value, sample point
//   m_        out  tdata: interpolated density, 24 fractional bits
//   cfg_wr_   in   extent register index and value
//
// A write beat stores its voxel in the cycle it is accepted; ready stays high.
// A sample beat blocks the next beat until its result is loaded: four
// weight products, then for each of the eight corners a RAM read, voxel
// times z weight, times xy weight and accumulate, all through the one shared
// multiplier and the one RAM port, then the load, held while m_ stalls.
// Reset clears the sequencer, the output valid and the extent registers (64);
// the voxel RAM is not cleared. A stalled result waits in the output
// register while the next beat is taken.
// ----------------------------------------------------------------------------
module trilinear_volume_sampler #(
    parameter int SIDE      = tvs_pkg::SIDE_DEF,
    parameter int FRAC_BITS = tvs_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: voxel_i, voxel_j, voxel_k, voxel_value, coord_x, coord_y,
    //          coord_z, zero fill
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tvs_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: kind
    input  logic [0:0]                      s_tuser,
    // m_tdata: sample_value
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tvs_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [tvs_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [tvs_pkg::SIZE_W-1:0]      cfg_wr_data
);

    localparam int DEPTH = SIDE * SIDE * SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int W_W   = FRAC_BITS + 1;
    localparam int A_W   = FRAC_BITS + 18;
    localparam int B_W   = 2 * FRAC_BITS + 1;
    localparam int ACC_W = 3 * FRAC_BITS + 18;
    localparam int SH_L  = (3 * FRAC_BITS <= tvs_pkg::OUT_FRAC) ?
                           tvs_pkg::OUT_FRAC - 3 * FRAC_BITS : 0;
    localparam int SH_R  = (3 * FRAC_BITS > tvs_pkg::OUT_FRAC) ?
                           3 * FRAC_BITS - tvs_pkg::OUT_FRAC : 0;
    localparam int SCL_W = ACC_W + tvs_pkg::OUT_FRAC;
    localparam int IDX_W = tvs_pkg::IDX_W;
    localparam int EXT_W = tvs_pkg::EXT_W;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_WXY  = 6'b000010,
        ST_RD   = 6'b000100,
        ST_M1   = 6'b001000,
        ST_M2   = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;

    // ------------------------------------------------------------------------
    // Beat fields
    // ------------------------------------------------------------------------
    logic                              kind;
    logic [tvs_pkg::INDEX_W-1:0]       voxel_i, voxel_j, voxel_k;
    logic [tvs_pkg::VOXEL_W-1:0]       voxel_value;
    logic signed [tvs_pkg::COORD_W-1:0] coord_x, coord_y, coord_z;

    assign kind        = s_tuser[0];
    assign voxel_i     = s_tdata[tvs_pkg::VI_LSB +: tvs_pkg::INDEX_W];
    assign voxel_j     = s_tdata[tvs_pkg::VJ_LSB +: tvs_pkg::INDEX_W];
    assign voxel_k     = s_tdata[tvs_pkg::VK_LSB +: tvs_pkg::INDEX_W];
    assign voxel_value = s_tdata[tvs_pkg::VVAL_LSB +: tvs_pkg::VOXEL_W];
    assign coord_x     = $signed(s_tdata[tvs_pkg::CX_LSB +: tvs_pkg::COORD_W]);
    assign coord_y     = $signed(s_tdata[tvs_pkg::CY_LSB +: tvs_pkg::COORD_W]);
    assign coord_z     = $signed(s_tdata[tvs_pkg::CZ_LSB +: tvs_pkg::COORD_W]);

    logic in_beat, write_beat, sample_beat;
    assign s_tready    = (state_reg == ST_IDLE);
    assign in_beat     = s_tvalid && s_tready;
    assign write_beat  = in_beat && (kind == tvs_pkg::KIND_WRITE);
    assign sample_beat = in_beat && (kind == tvs_pkg::KIND_SAMPLE);

    // ------------------------------------------------------------------------
    // Extent registers
    // ------------------------------------------------------------------------
    logic [tvs_pkg::SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= tvs_pkg::SIZE_RESET;
            size_y_reg <= tvs_pkg::SIZE_RESET;
            size_z_reg <= tvs_pkg::SIZE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                tvs_pkg::REG_SIZE_X: size_x_reg <= cfg_wr_data;
                tvs_pkg::REG_SIZE_Y: size_y_reg <= cfg_wr_data;
                tvs_pkg::REG_SIZE_Z: size_z_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Clamp each extent to the stored side
    logic [EXT_W-1:0] ext_x, ext_y, ext_z;
    logic [EXT_W-1:0] raw_x, raw_y, raw_z;

    assign raw_x = EXT_W'(size_x_reg);
    assign raw_y = EXT_W'(size_y_reg);
    assign raw_z = EXT_W'(size_z_reg);
    assign ext_x = (raw_x > EXT_W'(SIDE)) ? EXT_W'(SIDE) : raw_x;
    assign ext_y = (raw_y > EXT_W'(SIDE)) ? EXT_W'(SIDE) : raw_y;
    assign ext_z = (raw_z > EXT_W'(SIDE)) ? EXT_W'(SIDE) : raw_z;

    // ------------------------------------------------------------------------
    // Sample setup: base voxel and fractions, latched on a sample beat
    // ------------------------------------------------------------------------
    logic signed [IDX_W-1:0] bx_reg, by_reg, bz_reg;
    logic [FRAC_BITS-1:0]    fx_reg, fy_reg, fz_reg;
    logic signed [IDX_W-1:0] bx_next, by_next, bz_next;

    assign bx_next = IDX_W'(coord_x >>> FRAC_BITS) + $signed(IDX_W'(ext_x >> 1));
    assign by_next = IDX_W'(coord_y >>> FRAC_BITS) + $signed(IDX_W'(ext_y >> 1));
    assign bz_next = IDX_W'(coord_z >>> FRAC_BITS) + $signed(IDX_W'(ext_z >> 1));

    always_ff @(posedge aclk) begin
        if (sample_beat) begin
            bx_reg <= bx_next;
            by_reg <= by_next;
            bz_reg <= bz_next;
            fx_reg <= coord_x[FRAC_BITS-1:0];
            fy_reg <= coord_y[FRAC_BITS-1:0];
            fz_reg <= coord_z[FRAC_BITS-1:0];
        end
    end

    // Axis weights: one minus fraction for the lower corner, fraction above
    logic [W_W-1:0] wx_sel, wy_sel, wz_sel;

    assign wx_sel = cnt_reg[1] ? W_W'(fx_reg) : W_W'(1 << FRAC_BITS) - W_W'(fx_reg);
    assign wy_sel = cnt_reg[0] ? W_W'(fy_reg) : W_W'(1 << FRAC_BITS) - W_W'(fy_reg);
    assign wz_sel = cnt_reg[0] ? W_W'(fz_reg) : W_W'(1 << FRAC_BITS) - W_W'(fz_reg);

    // ------------------------------------------------------------------------
    // Corner address and bounds check
    // ------------------------------------------------------------------------
    logic signed [IDX_W-1:0] ci, cj, ck;
    logic                    corner_in;
    logic [AW-1:0]           rd_addr, wr_addr;
    logic                    wr_ok;

    assign ci = bx_reg + $signed(IDX_W'(cnt_reg[2]));
    assign cj = by_reg + $signed(IDX_W'(cnt_reg[1]));
    assign ck = bz_reg + $signed(IDX_W'(cnt_reg[0]));

    assign corner_in = !ci[IDX_W-1] && ($unsigned(ci) < IDX_W'(ext_x)) &&
                       !cj[IDX_W-1] && ($unsigned(cj) < IDX_W'(ext_y)) &&
                       !ck[IDX_W-1] && ($unsigned(ck) < IDX_W'(ext_z));

    assign rd_addr = (AW'($unsigned(ci)) * AW'(SIDE) + AW'($unsigned(cj))) * AW'(SIDE)
                     + AW'($unsigned(ck));

    // Drop writes that fall outside the stored cube
    assign wr_ok   = (EXT_W'(voxel_i) < EXT_W'(SIDE)) &&
                     (EXT_W'(voxel_j) < EXT_W'(SIDE)) &&
                     (EXT_W'(voxel_k) < EXT_W'(SIDE));
    assign wr_addr = (AW'(voxel_i) * AW'(SIDE) + AW'(voxel_j)) * AW'(SIDE) + AW'(voxel_k);

    // ------------------------------------------------------------------------
    // Voxel RAM
    // ------------------------------------------------------------------------
    logic                        ram_we;
    logic [AW-1:0]               ram_addr;
    logic [tvs_pkg::VOXEL_W-1:0] ram_rdata;
    logic                        inb_reg;

    assign ram_we   = write_beat && wr_ok;
    assign ram_addr = (state_reg == ST_IDLE) ? wr_addr : rd_addr;

    tvs_ram #(
        .WIDTH (tvs_pkg::VOXEL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (voxel_value),
        .rdata (ram_rdata)
    );

    // Remember whether the corner being read lies inside the volume
    always_ff @(posedge aclk) begin
        if (state_reg == ST_RD) begin
            inb_reg <= corner_in;
        end
    end

    // ------------------------------------------------------------------------
    // Shared multiplier operands
    // ------------------------------------------------------------------------
    tvs_pkg::mac_op_t          mac_op;
    logic signed [A_W-1:0]     mac_a;
    logic [B_W-1:0]            mac_b;
    logic signed [A_W+B_W:0]   mac_prod;
    logic signed [ACC_W-1:0]   mac_acc;
    logic [B_W-1:0]            wxy_reg [4];
    logic                      wcap_reg;
    logic [1:0]                wcap_idx_reg;

    always_comb begin
        mac_op = tvs_pkg::MAC_IDLE;
        mac_a  = '0;
        mac_b  = '0;
        case (state_reg)
            ST_IDLE: begin
                if (sample_beat) begin
                    mac_op = tvs_pkg::MAC_CLR;
                end
            end
            ST_WXY: begin
                mac_op = tvs_pkg::MAC_MUL;
                mac_a  = $signed(A_W'(wx_sel));
                mac_b  = B_W'(wy_sel);
            end
            ST_M1: begin
                mac_op = tvs_pkg::MAC_MUL;
                mac_a  = inb_reg ? A_W'($signed(ram_rdata)) : '0;
                mac_b  = B_W'(wz_sel);
            end
            ST_M2: begin
                mac_op = tvs_pkg::MAC_ACC;
                mac_a  = A_W'(mac_prod);
                mac_b  = wxy_reg[cnt_reg[2:1]];
            end
            default: begin
            end
        endcase
    end

    tvs_mac #(
        .A_W   (A_W),
        .B_W   (B_W),
        .ACC_W (ACC_W)
    ) u_mac (
        .aclk (aclk),
        .op   (mac_op),
        .a    (mac_a),
        .b    (mac_b),
        .prod (mac_prod),
        .acc  (mac_acc)
    );

    // Capture each xy weight product in the cycle after it was issued
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcap_reg <= 1'b0;
        end else begin
            wcap_reg <= (state_reg == ST_WXY);
        end
    end

    always_ff @(posedge aclk) begin
        wcap_idx_reg <= cnt_reg[1:0];
        if (wcap_reg) begin
            wxy_reg[wcap_idx_reg] <= B_W'(mac_prod);
        end
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    logic                         out_valid_reg;
    logic [tvs_pkg::OUT_W-1:0]    out_data_reg;
    logic                         out_load;
    logic signed [SCL_W-1:0]      scl;
    logic [tvs_pkg::OUT_W-1:0]    out_value;

    // Align the sum to 24 fractional bits; right shift floors
    assign scl       = SCL_W'(mac_acc);
    assign out_value = tvs_pkg::OUT_W'((scl <<< SH_L) >>> SH_R);
    assign out_load  = (state_reg == ST_FIN) && (!out_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= out_value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = tvs_pkg::M_TDATA_W'(out_data_reg);

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (sample_beat) begin
                    state_next = ST_WXY;
                end
            end
            ST_WXY: begin
                if (cnt_reg[1:0] == 2'b11) begin
                    cnt_next   = '0;
                    state_next = ST_RD;
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            ST_RD: begin
                state_next = ST_M1;
            end
            ST_M1: begin
                state_next = ST_M2;
            end
            ST_M2: begin
                if (cnt_reg == 3'b111) begin
                    state_next = ST_FIN;
                end else begin
                    cnt_next   = cnt_reg + 3'd1;
                    state_next = ST_RD;
                end
            end
            ST_FIN: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_sample_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        sample_beat |=> state_reg == ST_WXY)
        else $error("sample beat did not start the weight phase");

    a_last_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && $past(state_reg) == ST_M2) |-> $past(cnt_reg) == 3'b111)
        else $error("finished before the eighth corner");

    a_read_before_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_M1 |-> $past(state_reg) == ST_RD)
        else $error("voxel multiply without a preceding RAM read");

    a_wxy_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        wcap_reg |-> (state_reg == ST_WXY || state_reg == ST_RD))
        else $error("weight capture outside the weight phase");

    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_FIN)
        else $error("result appeared without a finished sample");

endmodule
